/* rtl/core/brg_pkg.sv */
`timescale 1ns / 1ps

package brg_pkg;

    localparam int MAX_STEPS = 64;

    localparam int LEVEL_W  = 16;
    localparam int PCT_W    = 15;
    localparam int STEPS_W  = 7;
    localparam int PROD_W   = LEVEL_W + PCT_W;
    localparam int REM_W    = PCT_W;
    localparam int CNT_W    = 5;
    localparam int MUL_W    = 22;
    localparam int SCALE_SH = 10;
    localparam int RECIP_SH = 26;

    localparam logic [PCT_W-1:0]   PCT_MIN_Q88 = 15'd1280;
    localparam logic [PCT_W-1:0]   PCT_MAX_Q88 = 15'd25600;
    localparam logic [STEPS_W-1:0] STEPS_MAX   = STEPS_W'(MAX_STEPS);

    // ceil(2^26 / 25), exact floor for dividends below 2^21
    localparam logic [MUL_W-1:0] RECIP_25 = MUL_W'(2684355);

    localparam logic [CNT_W-1:0] DIV_ITER_STEP = CNT_W'(LEVEL_W);

    typedef enum logic [1:0] {
        CFG_MAX_LEVEL   = 2'd0,
        CFG_NUM_STEPS   = 2'd1,
        CFG_STEP_PERIOD = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_T,
        ST_CHECK,
        ST_DIV_S,
        ST_RAMP
    } state_t;

endpackage

/* rtl/core/brightness_ramp_generator.sv */
`timescale 1ns / 1ps

// backlight fade ramp generator
// s_axis: one request word, percent in signed q8.8 and the level now in effect.
// m_axis: the ramp levels in order, each with its hold time; tlast marks the
// final level, which equals the target. a request whose target equals the
// present level gives no word; a zero step period gives one word at once.
// cfg: register writes by index (0 max level, 1 step count, 2 step period),
// taken with cfg_ready tied high; the user must write them only while no
// request is busy, and the block itself does not enforce this.
// datapath: one shared multiplier forms max level times percent in ST_MUL
// and scales it by 1/25600 through a reciprocal in ST_DIV_T; a restoring
// divider then forms the step size, and the ramp advances one step per
// cycle while the output register is free to take a word.
// s_axis_tready is high only between requests.
// an output register holds each word; a stall on m_axis freezes the ramp
// step, and a new request is taken while the last word still waits.
// reset clears the sequencer and output valid and loads the register
// defaults 255, 20 and 60.

module brightness_ramp_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // request_pct, present_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // level, hold_ms
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import brg_pkg::*;

    state_t state_reg, state_next;

    logic [LEVEL_W-1:0] max_level_reg;
    logic [STEPS_W-1:0] num_steps_reg;
    logic [LEVEL_W-1:0] step_period_reg;

    logic [PCT_W-1:0]   pct_reg, pct_next;
    logic [LEVEL_W-1:0] present_reg, present_next;
    logic [PROD_W-1:0]  quo_reg, quo_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [REM_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic [STEPS_W-1:0] k_reg, k_next;
    logic [LEVEL_W-1:0] acc_q_reg, acc_q_next;
    logic [STEPS_W-1:0] acc_r_reg, acc_r_next;

    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] hold_reg, hold_next;
    logic               last_reg, last_next;

    logic signed [15:0]   req_s;
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [2*MUL_W-1:0]   mul_p;
    logic [STEPS_W-1:0]   n_eff;
    logic [REM_W:0]       rem_sh;
    logic                 rem_ge;
    logic [REM_W-1:0]     rem_step;
    logic [PROD_W-1:0]    quo_step;
    logic [LEVEL_W-1:0]   target;
    logic                 tgt_below;
    logic [LEVEL_W-1:0]   mag;
    logic [STEPS_W:0]     sum_r;
    logic                 carry;
    logic [LEVEL_W-1:0]   acc_q_step;
    logic [STEPS_W-1:0]   acc_r_step;
    logic [LEVEL_W-1:0]   ramp_level;
    logic                 slot_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg   <= 16'd255;
            num_steps_reg   <= 7'd20;
            step_period_reg <= 16'd60;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_LEVEL:   max_level_reg   <= cfg_data;
                CFG_NUM_STEPS:   num_steps_reg   <= cfg_data[STEPS_W-1:0];
                CFG_STEP_PERIOD: step_period_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (num_steps_reg == '0)
            n_eff = STEPS_W'(1);
        else if (num_steps_reg > STEPS_MAX)
            n_eff = STEPS_MAX;
        else
            n_eff = num_steps_reg;
    end

    assign req_s = s_axis_tdata[15:0];

    // shared multiplier: level times percent, then floor(x / 25) by reciprocal
    always_comb
    begin
        if (state_reg == ST_DIV_T)
        begin
            mul_a = MUL_W'(quo_reg[PROD_W-1:SCALE_SH]);
            mul_b = RECIP_25;
        end
        else
        begin
            mul_a = MUL_W'(max_level_reg);
            mul_b = MUL_W'(pct_reg);
        end
    end

    assign mul_p = mul_a * mul_b;

    // restoring divider for the step size, one quotient bit per cycle
    assign rem_sh   = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, div_reg};
    assign rem_step = rem_ge ? REM_W'(rem_sh - {1'b0, div_reg}) : rem_sh[REM_W-1:0];
    assign quo_step = {quo_reg[PROD_W-2:0], rem_ge};

    assign target    = quo_reg[LEVEL_W-1:0];
    assign tgt_below = target < present_reg;
    assign mag       = tgt_below ? present_reg - target : target - present_reg;

    // ramp accumulator: quotient and remainder of |d|*k/n, stepped by |d|/n
    assign sum_r      = {1'b0, acc_r_reg} + {1'b0, rem_reg[STEPS_W-1:0]};
    assign carry      = sum_r >= {1'b0, n_eff};
    assign acc_r_step = carry ? STEPS_W'(sum_r - {1'b0, n_eff}) : sum_r[STEPS_W-1:0];
    assign acc_q_step = acc_q_reg + quo_reg[LEVEL_W-1:0] + {{(LEVEL_W-1){1'b0}}, carry};
    assign ramp_level = neg_reg ? present_reg - acc_q_step : present_reg + acc_q_step;

    assign slot_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pct_next       = pct_reg;
        present_next   = present_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        k_next         = k_reg;
        acc_q_next     = acc_q_reg;
        acc_r_next     = acc_r_reg;
        level_next     = level_reg;
        hold_next      = hold_reg;
        last_next      = last_reg;
        out_valid_next = m_axis_tready ? 1'b0 : out_valid_reg;
        s_axis_tready  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (req_s > $signed({1'b0, PCT_MAX_Q88}))
                        pct_next = PCT_MAX_Q88;
                    else if (req_s < $signed({1'b0, PCT_MIN_Q88}))
                        pct_next = PCT_MIN_Q88;
                    else
                        pct_next = req_s[PCT_W-1:0];
                    present_next = s_axis_tdata[31:16];
                    state_next   = ST_MUL;
                end
            end

            ST_MUL:
            begin
                quo_next   = mul_p[PROD_W-1:0];
                state_next = ST_DIV_T;
            end

            ST_DIV_T:
            begin
                quo_next   = PROD_W'(mul_p[RECIP_SH+LEVEL_W-1:RECIP_SH]);
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (target == present_reg)
                    state_next = ST_IDLE;
                else if (step_period_reg == '0)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        level_next     = target;
                        hold_next      = '0;
                        last_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    neg_next   = tgt_below;
                    quo_next   = {mag, {(PROD_W-LEVEL_W){1'b0}}};
                    rem_next   = '0;
                    div_next   = {{(REM_W-STEPS_W){1'b0}}, n_eff};
                    cnt_next   = DIV_ITER_STEP;
                    k_next     = STEPS_W'(1);
                    acc_q_next = '0;
                    acc_r_next = '0;
                    state_next = ST_DIV_S;
                end
            end

            ST_DIV_S:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_RAMP;
            end

            ST_RAMP:
            begin
                if (slot_free)
                begin
                    acc_q_next = acc_q_step;
                    acc_r_next = acc_r_step;
                    k_next     = k_reg + STEPS_W'(1);
                    if (acc_q_step != acc_q_reg)
                    begin
                        out_valid_next = 1'b1;
                        level_next     = ramp_level;
                        hold_next      = step_period_reg;
                        last_next      = k_reg == n_eff;
                    end
                    if (k_reg == n_eff)
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        pct_reg     <= pct_next;
        present_reg <= present_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        cnt_reg     <= cnt_next;
        neg_reg     <= neg_next;
        k_reg       <= k_next;
        acc_q_reg   <= acc_q_next;
        acc_r_reg   <= acc_r_next;
        level_reg   <= level_next;
        hold_reg    <= hold_next;
        last_reg    <= last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {hold_reg, level_reg};
    assign m_axis_tlast  = last_reg;

    // final ramp step always produces the flagged target word
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RAMP && k_reg == n_eff && slot_free
        |=> m_axis_tvalid && m_axis_tlast && state_reg == ST_IDLE)
        else $error("final ramp step did not emit last word");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RAMP |-> acc_r_reg < n_eff)
        else $error("ramp remainder out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RAMP |-> k_reg != '0 && k_reg <= n_eff)
        else $error("ramp step count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_S |-> cnt_reg != '0)
        else $error("divider count underflow");

endmodule
